// ===== rtl/spq_pkg.sv =====
// Shared types, sizes and codes for the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] item_value;
        logic signed [31:0] item_rank;
    } req_item_t;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic [1:0]         status;
        logic [OCC_W-1:0]   occupancy;
    } rsp_item_t;

    typedef struct packed {
        logic load;
        logic commit;
    } spq_cmd_t;

    typedef struct packed {
        logic rsp_free;
    } spq_status_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
// Controller state machine: sequences capture and execution of one item.
module spq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  spq_pkg::spq_status_t status,
    output spq_pkg::spq_cmd_t   cmd
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        req_stall  = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the result register can take the answer
                if (status.rsp_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/spq_datapath.sv =====
// Datapath: sorted register chain, entry count and result register.
module spq_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spq_pkg::req_item_t   req,
    input  spq_pkg::spq_cmd_t    cmd,
    output spq_pkg::spq_status_t status,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output spq_pkg::rsp_item_t   rsp
);
    import spq_pkg::*;

    req_item_t          op_reg;
    logic signed [31:0] rank_reg  [CAPACITY];
    logic signed [31:0] value_reg [CAPACITY];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_item_t          rsp_reg;
    rsp_item_t          rsp_next;

    logic [CAPACITY-1:0] gt;
    logic                full;
    logic                empty;
    logic                do_ins;
    logic                do_del;

    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign do_ins = cmd.commit && (op_reg.opcode == OP_INSERT) && !full;
    assign do_del = cmd.commit && (op_reg.opcode == OP_DELETE) && !empty;

    // Empty slots count as ranking above the new entry.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            gt[i] = (CNT_W'(i) >= count_reg) || (rank_reg[i] > op_reg.item_rank);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic               prev_gt;
        logic signed [31:0] prev_rank;
        logic signed [31:0] prev_value;
        logic signed [31:0] next_rank;
        logic signed [31:0] next_value;

        if (g == 0)
        begin : g_first
            assign prev_gt    = 1'b0;
            assign prev_rank  = op_reg.item_rank;
            assign prev_value = op_reg.item_value;
        end
        else
        begin : g_rest
            assign prev_gt    = gt[g-1];
            assign prev_rank  = rank_reg[g-1];
            assign prev_value = value_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign next_rank  = rank_reg[g];
            assign next_value = value_reg[g];
        end
        else
        begin : g_mid
            assign next_rank  = rank_reg[g+1];
            assign next_value = value_reg[g+1];
        end

        always_ff @(posedge clk)
        begin
            if (do_ins && gt[g])
            begin
                // first greater slot takes the new entry, later ones shift up
                if (!prev_gt)
                begin
                    rank_reg[g]  <= op_reg.item_rank;
                    value_reg[g] <= op_reg.item_value;
                end
                else
                begin
                    rank_reg[g]  <= prev_rank;
                    value_reg[g] <= prev_value;
                end
            end
            else if (do_del)
            begin
                rank_reg[g]  <= next_rank;
                value_reg[g] <= next_value;
            end
        end
    end

    always_comb
    begin
        count_next             = count_reg;
        rsp_next.removed_value = '0;
        rsp_next.status        = ST_OK;
        if (op_reg.opcode == OP_INSERT)
        begin
            if (full)
            begin
                rsp_next.status = ST_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (empty)
            begin
                rsp_next.status = ST_EMPTY;
            end
            else
            begin
                rsp_next.removed_value = value_reg[0];
                count_next             = count_reg - 1'b1;
            end
        end
        rsp_next.occupancy = OCC_W'(count_next);
    end

    assign rsp_valid_next  = cmd.commit || (rsp_valid_reg && rsp_stall);
    assign status.rsp_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= req;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// Sorted priority queue: smallest rank leaves first, equal ranks in arrival order.
//
// Request channel (req_valid / req_stall / req): each item is an insert of a
// (rank, value) pair or a delete of the front entry. Response channel
// (rsp_valid / rsp_stall / rsp): exactly one item per request, carrying the
// removed value (zero unless a delete succeeded), a status code (ok, delete
// on empty, insert on full) and the occupancy after the operation.
// A request is captured in the operand register and its response is written to
// the response register once that register is free. The block takes no new
// request until the current one is done; the controller captures a request in
// one state and updates the whole register chain in parallel in the next.
// The response register parts the two sides: a new request is accepted while
// an earlier response still waits. If the receiver stalls, the next request
// is held in execution until the waiting response is taken.
// Reset empties the queue at once (count to zero) and clears any pending
// response; stored entries need no clearing.
module sorted_priority_queue_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  spq_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output spq_pkg::rsp_item_t rsp
);
    import spq_pkg::*;

    spq_cmd_t    cmd;
    spq_status_t status;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    spq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
